// ----- design/erm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_pkg
// Shared types and constants of the echo reachability monitor.
// ----------------------------------------------------------------------------
package erm_pkg;

  localparam int unsigned TableDepthDef = 64;
  localparam int unsigned PeriodReset   = 5;

  // 0x0800 (type/code) plus the fixed data words 0x0405 .. 0x0e0f
  localparam logic [15:0] ReqSumBase = 16'h3e3c;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_ROUND  = 2'd2,
    ACT_REPLY  = 2'd3
  } action_e;

  typedef enum logic {
    CFG_OUR_IDENT = 1'b0,
    CFG_PERIOD    = 1'b1
  } cfg_index_e;

  typedef enum logic [3:0] {
    ST_ADDED     = 4'd0,
    ST_REENABLED = 4'd1,
    ST_FULL      = 4'd2,
    ST_REMOVED   = 4'd3,
    ST_ABSENT    = 4'd4,
    ST_HEARD     = 4'd5,
    ST_SHORT     = 4'd6,
    ST_TYPE      = 4'd7,
    ST_IDENT     = 4'd8,
    ST_CHECKSUM  = 4'd9
  } status_e;

  typedef enum logic [2:0] {
    CMD_ADD,
    CMD_REMOVE,
    CMD_ROUND,
    CMD_HEARD,
    CMD_STATUS
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e     op;
    status_e     code;
    logic [31:0] addr;
    logic [31:0] stamp;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  status;
    logic [31:0] addr;
    logic [15:0] seq;
    logic [31:0] stamp;
    logic [15:0] cksum;
    logic [31:0] missed;
    logic        last;
  } res_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_EXAM,
    BK_MUL,
    BK_EMIT,
    BK_FINISH
  } back_state_e;

  function automatic logic [15:0] fold_cksum(input logic [19:0] s);
    logic [16:0] a;
    logic [16:0] b;
    a = {13'd0, s[19:16]} + {1'b0, s[15:0]};
    b = {1'b0, a[15:0]} + {16'd0, a[16]};
    return ~b[15:0];
  endfunction

endpackage

// ----- design/erm_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_front
// Accepts input transactions, checks replies and queues commands.
// ----------------------------------------------------------------------------
module erm_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [1:0]    action_i,
  input  logic [31:0]   dest_addr_i,
  input  logic [5:0]    rx_length_i,
  input  logic [3:0]    ip_header_words_i,
  input  logic [7:0]    msg_type_i,
  input  logic [7:0]    msg_code_i,
  input  logic [15:0]   msg_checksum_i,
  input  logic [15:0]   msg_ident_i,
  input  logic [15:0]   msg_sequence_i,
  input  logic [31:0]   reply_stamp_i,
  input  logic [47:0]   tail_high_i,
  input  logic [47:0]   tail_low_i,
  input  logic [15:0]   our_ident_i,
  output logic          push_o,
  output erm_pkg::cmd_t push_cmd_o,
  input  logic          full_i
);
  import erm_pkg::*;

  logic        busy_q, busy_d;
  logic        ph_q, ph_d;
  logic [1:0]  act_q;
  logic [31:0] addr_q;
  logic [5:0]  len_q;
  logic [3:0]  hw_q;
  logic [7:0]  type_q, code_q;
  logic [15:0] ck_q, id_q, seq_q;
  logic [31:0] stamp_q;
  logic [47:0] th_q, tl_q;
  logic [19:0] sum_q, sum_d;
  logic [6:0]  min_len;
  logic        accept;

  assign in_stall_o = busy_q;
  assign accept     = in_valid_i && !busy_q;
  assign min_len    = {1'b0, hw_q, 2'b00} + 7'd24;

  always_comb begin
    sum_d = {4'd0, type_q, code_q} + {4'd0, id_q} + {4'd0, seq_q}
          + {4'd0, stamp_q[31:16]} + {4'd0, stamp_q[15:0]}
          + {4'd0, th_q[47:32]} + {4'd0, th_q[31:16]} + {4'd0, th_q[15:0]}
          + {4'd0, tl_q[47:32]} + {4'd0, tl_q[31:16]} + {4'd0, tl_q[15:0]};
  end

  always_comb begin
    busy_d           = busy_q;
    ph_d             = ph_q;
    push_o           = 1'b0;
    push_cmd_o.addr  = addr_q;
    push_cmd_o.stamp = stamp_q;
    push_cmd_o.code  = ST_HEARD;
    push_cmd_o.op    = CMD_STATUS;
    unique case (action_e'(act_q))
      ACT_ADD:    push_cmd_o.op = CMD_ADD;
      ACT_REMOVE: push_cmd_o.op = CMD_REMOVE;
      ACT_ROUND:  push_cmd_o.op = CMD_ROUND;
      ACT_REPLY: begin
        if ({1'b0, len_q} < min_len) begin
          push_cmd_o.code = ST_SHORT;
        end else if (type_q != 8'd0) begin
          push_cmd_o.code = ST_TYPE;
        end else if (id_q != our_ident_i) begin
          push_cmd_o.code = ST_IDENT;
        end else if (fold_cksum(sum_q) != ck_q) begin
          push_cmd_o.code = ST_CHECKSUM;
        end else begin
          push_cmd_o.op = CMD_HEARD;
        end
      end
      default: push_cmd_o.op = CMD_STATUS;
    endcase
    if (accept) begin
      busy_d = 1'b1;
      ph_d   = 1'b0;
    end else if (busy_q && !ph_q) begin
      ph_d = 1'b1;
    end else if (busy_q && ph_q && !full_i) begin
      push_o = 1'b1;
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ph_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      ph_q   <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q   <= action_i;
      addr_q  <= dest_addr_i;
      len_q   <= rx_length_i;
      hw_q    <= ip_header_words_i;
      type_q  <= msg_type_i;
      code_q  <= msg_code_i;
      ck_q    <= msg_checksum_i;
      id_q    <= msg_ident_i;
      seq_q   <= msg_sequence_i;
      stamp_q <= reply_stamp_i;
      th_q    <= tail_high_i;
      tl_q    <= tail_low_i;
    end
    sum_q <= sum_d;
  end

endmodule

// ----- design/erm_cmd_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_cmd_fifo
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module erm_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  erm_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output erm_pkg::cmd_t pop_cmd_o
);
  import erm_pkg::*;

  cmd_t       slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o    = cnt_q == 2'd2;
  assign empty_o   = cnt_q == 2'd0;
  assign pop_cmd_o = slot_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wptr_q] <= push_cmd_i;
  end

endmodule

// ----- design/erm_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_back
// Walks the address table for each command and drives the result register.
// ----------------------------------------------------------------------------
module erm_back #(
  parameter int unsigned TABLE_DEPTH = erm_pkg::TableDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  erm_pkg::cmd_t cmd_i,
  output logic          pop_o,
  input  logic [15:0]   our_ident_i,
  input  logic [15:0]   period_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output erm_pkg::res_t out_o
);
  import erm_pkg::*;

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef struct packed {
    logic [31:0] addr;
    logic        off;
    logic [31:0] sent;
    logic [31:0] heard;
  } entry_t;

  entry_t      mem_q [TABLE_DEPTH];
  entry_t      rd_q, wdata;
  logic        we, rd_en;
  logic [IW-1:0] waddr;

  back_state_e st_q, st_d;
  cmd_t        cmd_q, cmd_d;
  logic [CW-1:0] idx_q, idx_d, cnt_q, cnt_d, idx_nx;
  logic        hit_q, hit_d;
  logic [31:0] round_q, round_d;
  logic [15:0] seq_q, seq_d;
  logic [31:0] q_q, q_d, dlt, qm;
  logic [47:0] prod_q, prod_d;
  logic [15:0] ck_q, ck_d;
  logic [31:0] taddr_q, taddr_d;
  res_t        pend_q, pend_d, out_q, out_d, load_res, req;
  logic        pend_v_q, pend_v_d, out_v_q, out_v_d, load;
  logic        out_free, match;
  logic [19:0] rsum;

  assign out_free    = !out_v_q || !out_stall_i;
  assign out_valid_o = out_v_q;
  assign out_o       = out_q;
  assign idx_nx      = idx_q + CW'(1);
  assign match       = rd_q.addr == cmd_q.addr;
  assign dlt         = round_q - rd_q.heard;
  assign qm          = dlt - 32'd1;
  assign rsum        = {4'd0, ReqSumBase} + {4'd0, our_ident_i} + {4'd0, seq_q}
                     + {4'd0, round_q[31:16]} + {4'd0, round_q[15:0]};

  always_comb begin
    req.kind   = 1'b1;
    req.status = 4'd0;
    req.addr   = taddr_q;
    req.seq    = seq_q;
    req.stamp  = round_q;
    req.cksum  = ck_q;
    req.missed = (|prod_q[47:32]) ? 32'hffff_ffff : prod_q[31:0];
    req.last   = 1'b0;
  end

  always_comb begin
    st_d     = st_q;
    cmd_d    = cmd_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    hit_d    = hit_q;
    round_d  = round_q;
    seq_d    = seq_q;
    q_d      = q_q;
    prod_d   = prod_q;
    ck_d     = ck_q;
    taddr_d  = taddr_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    pop_o    = 1'b0;
    we       = 1'b0;
    rd_en    = 1'b0;
    waddr    = idx_q[IW-1:0];
    wdata    = rd_q;
    load     = 1'b0;
    load_res = '0;
    load_res.addr = cmd_q.addr;
    load_res.last = 1'b1;
    unique case (st_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
          idx_d = '0;
          hit_d = 1'b0;
          st_d  = (cnt_q == '0 || cmd_i.op == CMD_STATUS) ? BK_FINISH : BK_READ;
        end
      end
      BK_READ: begin
        rd_en = 1'b1;
        st_d  = BK_EXAM;
      end
      BK_EXAM: begin
        st_d = (idx_nx == cnt_q) ? BK_FINISH : BK_READ;
        idx_d = idx_nx;
        case (cmd_q.op)
          CMD_ADD: begin
            if (match) begin
              hit_d = 1'b1;
              st_d  = BK_FINISH;
              if (rd_q.off) begin
                we    = 1'b1;
                wdata = '{addr: rd_q.addr, off: 1'b0, sent: round_q, heard: round_q};
              end
            end
          end
          CMD_REMOVE: begin
            if (match) begin
              hit_d     = 1'b1;
              st_d      = BK_FINISH;
              we        = 1'b1;
              wdata.off = 1'b1;
            end
          end
          CMD_HEARD: begin
            if (!rd_q.off && match && cmd_q.stamp > rd_q.heard &&
                cmd_q.stamp <= rd_q.sent) begin
              we          = 1'b1;
              wdata.heard = cmd_q.stamp;
            end
          end
          CMD_ROUND: begin
            if (!rd_q.off) begin
              we         = 1'b1;
              wdata.sent = round_q;
              q_d        = qm[31] ? 32'd0 : qm;
              taddr_d    = rd_q.addr;
              st_d       = BK_MUL;
            end
          end
          default: st_d = BK_FINISH;
        endcase
      end
      BK_MUL: begin
        prod_d = q_q * {16'd0, period_i};
        ck_d   = fold_cksum(rsum);
        st_d   = BK_EMIT;
      end
      BK_EMIT: begin
        if (!pend_v_q || out_free) begin
          if (pend_v_q) begin
            load     = 1'b1;
            load_res = pend_q;
          end
          pend_d   = req;
          pend_v_d = 1'b1;
          seq_d    = seq_q + 16'd1;
          st_d     = (idx_q == cnt_q) ? BK_FINISH : BK_READ;
        end
      end
      BK_FINISH: begin
        if (cmd_q.op == CMD_ROUND) begin
          if (!pend_v_q || out_free) begin
            if (pend_v_q) begin
              load          = 1'b1;
              load_res      = pend_q;
              load_res.last = 1'b1;
            end
            pend_v_d = 1'b0;
            round_d  = round_q + 32'd1;
            st_d     = BK_IDLE;
          end
        end else if (out_free) begin
          load = 1'b1;
          st_d = BK_IDLE;
          case (cmd_q.op)
            CMD_ADD: begin
              if (hit_q) begin
                load_res.status = ST_REENABLED;
              end else if (cnt_q == CW'(TABLE_DEPTH)) begin
                load_res.status = ST_FULL;
              end else begin
                load_res.status = ST_ADDED;
                we    = 1'b1;
                waddr = cnt_q[IW-1:0];
                wdata = '{addr: cmd_q.addr, off: 1'b0, sent: round_q, heard: round_q};
                cnt_d = cnt_q + CW'(1);
              end
            end
            CMD_REMOVE: load_res.status = hit_q ? ST_REMOVED : ST_ABSENT;
            CMD_HEARD:  load_res.status = ST_HEARD;
            default:    load_res.status = cmd_q.code;
          endcase
        end
      end
      default: st_d = BK_IDLE;
    endcase
  end

  always_comb begin
    out_d   = out_q;
    out_v_d = out_v_q && out_stall_i;
    if (load) begin
      out_d   = load_res;
      out_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= BK_IDLE;
      idx_q    <= '0;
      cnt_q    <= '0;
      hit_q    <= 1'b0;
      round_q  <= '0;
      seq_q    <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      st_q     <= st_d;
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
      hit_q    <= hit_d;
      round_q  <= round_d;
      seq_q    <= seq_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    q_q     <= q_d;
    prod_q  <= prod_d;
    ck_q    <= ck_d;
    taddr_q <= taddr_d;
    pend_q  <= pend_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (rd_en) rd_q <= mem_q[idx_q[IW-1:0]];
  end

endmodule

// ----- design/echo_reachability_monitor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_reachability_monitor
// Watched-address table with echo request rounds and reply checking.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with one port per field; action_i
// selects add, remove, run round or received reply. Output channel:
// out_valid_o / out_stall_i; add, remove and reply each yield one status
// result, a round yields one echo request per enabled entry (possibly none),
// and last_o marks the final result of each input transaction.
// The front captures a transaction, registers its checksum sum and hands
// a command to a two-entry queue, stalling the input until that hand-off;
// it takes the next transaction while the back is still busy. The back
// reads the table memory one entry at a time (read, then examine): add
// and remove stop at the first match, a reply or round visits all N live
// entries, each request passing through a multiply-and-checksum state
// and an emit state.
// Reset empties the table (count zero), clears round and sequence, sets
// the identifier to 0 and the period to 5. A stalled result holds in the
// output register and the back waits; the queue then fills and the front
// stalls the input.
// ----------------------------------------------------------------------------
module echo_reachability_monitor #(
  parameter int unsigned TABLE_DEPTH = erm_pkg::TableDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] dest_addr_i,
  input  logic [5:0]  rx_length_i,
  input  logic [3:0]  ip_header_words_i,
  input  logic [7:0]  msg_type_i,
  input  logic [7:0]  msg_code_i,
  input  logic [15:0] msg_checksum_i,
  input  logic [15:0] msg_ident_i,
  input  logic [15:0] msg_sequence_i,
  input  logic [31:0] reply_stamp_i,
  input  logic [47:0] tail_high_i,
  input  logic [47:0] tail_low_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [3:0]  status_o,
  output logic [31:0] target_addr_o,
  output logic [15:0] request_sequence_o,
  output logic [31:0] request_stamp_o,
  output logic [15:0] request_checksum_o,
  output logic [31:0] missed_time_o,
  output logic        last_o
);
  import erm_pkg::*;

  logic [15:0] ident_q, period_q;
  logic        push, full, pop, empty;
  cmd_t        push_cmd, pop_cmd;
  res_t        res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ident_q  <= '0;
      period_q <= 16'(PeriodReset);
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_OUR_IDENT: ident_q  <= cfg_wdata_i;
        CFG_PERIOD:    period_q <= cfg_wdata_i;
        default:       ident_q  <= ident_q;
      endcase
    end
  end

  erm_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .action_i, .dest_addr_i, .rx_length_i, .ip_header_words_i,
    .msg_type_i, .msg_code_i, .msg_checksum_i, .msg_ident_i,
    .msg_sequence_i, .reply_stamp_i, .tail_high_i, .tail_low_i,
    .our_ident_i (ident_q),
    .push_o      (push),
    .push_cmd_o  (push_cmd),
    .full_i      (full)
  );

  erm_cmd_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .pop_cmd_o  (pop_cmd)
  );

  erm_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk_i, .rst_ni,
    .empty_i     (empty),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .our_ident_i (ident_q),
    .period_i    (period_q),
    .out_valid_o,
    .out_stall_i,
    .out_o       (res)
  );

  assign kind_o             = res.kind;
  assign status_o           = res.status;
  assign target_addr_o      = res.addr;
  assign request_sequence_o = res.seq;
  assign request_stamp_o    = res.stamp;
  assign request_checksum_o = res.cksum;
  assign missed_time_o      = res.missed;
  assign last_o             = res.last;

endmodule

// ----- design/erm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_checker
// Port-level checks of the echo reachability monitor.
// ----------------------------------------------------------------------------
module erm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic        cfg_index_i,
  input logic [15:0] cfg_wdata_i,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  action_i,
  input logic [31:0] dest_addr_i,
  input logic [5:0]  rx_length_i,
  input logic [3:0]  ip_header_words_i,
  input logic [7:0]  msg_type_i,
  input logic [7:0]  msg_code_i,
  input logic [15:0] msg_checksum_i,
  input logic [15:0] msg_ident_i,
  input logic [15:0] msg_sequence_i,
  input logic [31:0] reply_stamp_i,
  input logic [47:0] tail_high_i,
  input logic [47:0] tail_low_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        kind_o,
  input logic [3:0]  status_o,
  input logic [31:0] target_addr_o,
  input logic [15:0] request_sequence_o,
  input logic [31:0] request_stamp_o,
  input logic [15:0] request_checksum_o,
  input logic [31:0] missed_time_o,
  input logic        last_o
);
  import erm_pkg::*;

  a_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(target_addr_o)
      && $stable(last_o) && $stable(kind_o))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid in reset");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !kind_o |-> last_o && request_sequence_o == 16'd0
      && missed_time_o == 32'd0)
    else $error("status result malformed");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !kind_o |-> status_o <= ST_CHECKSUM)
    else $error("status code out of range");

  a_req_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o |-> status_o == 4'd0)
    else $error("request carries status");

endmodule

bind echo_reachability_monitor erm_checker u_erm_checker (.*);
